### rtl/servo_pwm_mecanum_mixer_macros.svh
// assertion macros shared by the mixer rtl files
// no dependencies; included by every module that checks itself
`ifndef SERVO_PWM_MECANUM_MIXER_MACROS_SVH
`define SERVO_PWM_MECANUM_MIXER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define SMPM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define SMPM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/smpm_pkg.sv
// shared types and constants of the servo pwm mecanum mixer
// no dependencies; imported by every rtl module of the block
`default_nettype none

package smpm_pkg;

	localparam int CAP_MIN     = 50;   // 0.5 ms at 10 us per tick
	localparam int CAP_MAX     = 250;  // 2.5 ms at 10 us per tick
	localparam int NEUTRAL     = 150;  // center of the servo range
	localparam int FRAME_RESET = 2000; // 20 ms frame
	localparam int HALF_SQRT2_Q16 = 46341;
	localparam int Q_SHIFT     = 16;

	localparam int CAP_W   = 8;
	localparam int WIDTH_W = 9;
	localparam int FRAME_W = 12;
	localparam int CD_W    = 13;

	typedef logic [CAP_W-1:0]   cap_t;
	typedef logic [WIDTH_W-1:0] width_t;
	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [CD_W-1:0]    countdown_t;

endpackage

`default_nettype wire

### rtl/smpm_channel.sv
// servo input channel: high-time counter and clamped pulse capture
// depends on smpm_pkg and servo_pwm_mecanum_mixer_macros.svh
`default_nettype none
`include "servo_pwm_mecanum_mixer_macros.svh"

module smpm_channel #(
	parameter int COUNTER_BITS = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             en,
	input  wire             pin,
	output smpm_pkg::cap_t  cap_next
);
	import smpm_pkg::*;

	logic                    level_q;
	logic [COUNTER_BITS-1:0] count_q;
	logic [COUNTER_BITS-1:0] count_d;
	cap_t                    cap_q;
	cap_t                    cap_d;

	always_comb begin
		count_d = count_q;
		cap_d   = cap_q;
		if (pin == level_q) begin
			if (pin && (count_q != '1)) begin
				count_d = count_q + COUNTER_BITS'(1);
			end
		end else if (pin) begin
			count_d = COUNTER_BITS'(1);
		end else begin
			// falling edge: clamp into the legal servo range
			if (count_q < COUNTER_BITS'(CAP_MIN)) begin
				cap_d = CAP_W'(CAP_MIN);
			end else if (count_q > COUNTER_BITS'(CAP_MAX)) begin
				cap_d = CAP_W'(CAP_MAX);
			end else begin
				cap_d = count_q[CAP_W-1:0];
			end
		end
	end

	assign cap_next = cap_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			count_q <= '0;
			cap_q   <= CAP_W'(NEUTRAL);
		end else if (en) begin
			level_q <= pin;
			count_q <= count_d;
			cap_q   <= cap_d;
		end
	end

	`SMPM_ASSERT_NOW(a_cap_in_range, clk, arst_n, 1'b1,
		(cap_q >= CAP_W'(CAP_MIN)) && (cap_q <= CAP_W'(CAP_MAX)),
		"captured width outside servo range")

endmodule

`default_nettype wire

### rtl/smpm_pwm.sv
// one motor pwm generator: countdown timer and output level
// depends on smpm_pkg
`default_nettype none

module smpm_pwm (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              en,
	input  smpm_pkg::width_t width,
	input  smpm_pkg::frame_t frame,
	output logic             level
);
	import smpm_pkg::*;

	countdown_t cd_q;
	countdown_t cd_d;
	logic       level_q;

	always_comb begin
		if (cd_q <= CD_W'(1)) begin
			if (level_q) begin
				// low phase is frame minus width, at least one tick
				cd_d = (CD_W'(frame) > CD_W'(width)) ? CD_W'(frame) - CD_W'(width) : '0;
			end else begin
				cd_d = CD_W'(width);
			end
		end else begin
			cd_d = cd_q - CD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q    <= '0;
			level_q <= 1'b0;
		end else if (en) begin
			cd_q <= cd_d;
			if (cd_q <= CD_W'(1)) begin
				level_q <= ~level_q;
			end
		end
	end

	assign level = level_q;

endmodule

`default_nettype wire

### rtl/servo_pwm_mecanum_mixer.sv
// top level of the servo pwm mecanum mixer: stream ports, mixing arithmetic
// depends on smpm_pkg, smpm_channel, smpm_pwm and servo_pwm_mecanum_mixer_macros.svh
`default_nettype none
`include "servo_pwm_mecanum_mixer_macros.svh"

// each input transfer is one sample tick carrying the x, y and rotation servo
// pin levels; each tick yields exactly one output transfer with the four motor
// pwm pin levels after that tick. a tick passes through an input register and
// a result register with one short combinational step between them: pulse
// capture, the 45 degree mecanum mix (two 10x17 bit constant multiplies) and
// the four pwm countdowns. output valid is set as the tick leaves the input
// register, so a result never transfers in the same cycle as its input, and
// a new tick is taken every cycle as long as the output side drains. the user must
// write frame_ticks through cfg_wr_en / cfg_wr_data only while no tick is in flight;
// the block does not enforce this. it resets to 2000 ticks. COUNTER_BITS sets the
// width of the servo high-time counters, which saturate instead of wrapping.
module servo_pwm_mecanum_mixer #(
	parameter int COUNTER_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	// input stream
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,    // [0] x_pin, [1] y_pin, [2] rot_pin, [7:3] zero
	// output stream
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,    // [0] front_left_pin, [1] front_right_pin,
	                               // [2] rear_left_pin, [3] rear_right_pin, [7:4] zero
	// configuration
	input  wire        cfg_wr_en,
	input  wire  [11:0] cfg_wr_data // frame_ticks
);
	import smpm_pkg::*;

	localparam int NCH   = 3;
	localparam int NMOT  = 4;
	localparam int MIX_W = 27; // holds +-200 * 46341
	localparam int SUM_W = 10; // a +- b
	localparam int OFF_W = 9;  // captured - neutral
	localparam int F_W   = 12; // floored width before saturation

	localparam logic signed [MIX_W-1:0] MIX_K = MIX_W'(HALF_SQRT2_Q16);

	// floor(prod / 2^16) + neutral + c_term, saturated at zero
	function automatic width_t mix_width(logic signed [MIX_W-1:0] prod,
	                                     logic signed [OFF_W-1:0] c_term);
		logic signed [F_W-1:0] f;
		f = F_W'($signed(prod[MIX_W-1:Q_SHIFT])) + F_W'(NEUTRAL) + F_W'(c_term);
		return f[F_W-1] ? '0 : f[WIDTH_W-1:0];
	endfunction

	// input stage
	logic           valid_s1;
	logic [NCH-1:0] pins_s1;
	logic           advance;
	logic           m_tvalid_q;
	frame_t         frame_q;

	// tick moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pins_s1 <= s_tdata[NCH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= FRAME_W'(FRAME_RESET);
		end else if (cfg_wr_en) begin
			frame_q <= cfg_wr_data;
		end
	end

	// servo channels give this tick's captured widths
	cap_t cap_next [NCH];

	for (genvar i = 0; i < NCH; i++) begin : g_ch
		smpm_channel #(
			.COUNTER_BITS(COUNTER_BITS)
		) u_ch (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.pin      (pins_s1[i]),
			.cap_next (cap_next[i])
		);
	end

	// mecanum mix: sqrt(1/2) scaling of the diagonal terms in q16.16
	logic signed [OFF_W-1:0] a_off, b_off, c_off, c_neg;
	logic signed [SUM_W-1:0] d_diff, d_sum;
	logic signed [MIX_W-1:0] p_diff, p_sum;
	width_t                  motor_width [NMOT];

	always_comb begin
		a_off  = $signed({1'b0, cap_next[0]}) - OFF_W'(NEUTRAL);
		b_off  = $signed({1'b0, cap_next[1]}) - OFF_W'(NEUTRAL);
		c_off  = $signed({1'b0, cap_next[2]}) - OFF_W'(NEUTRAL);
		c_neg  = -c_off;
		d_diff = SUM_W'(a_off) - SUM_W'(b_off);
		d_sum  = SUM_W'(a_off) + SUM_W'(b_off);
		p_diff = MIX_W'(d_diff) * MIX_K;
		p_sum  = MIX_W'(d_sum) * MIX_K;
		motor_width[0] = mix_width(p_diff, c_neg); // front left
		motor_width[1] = mix_width(p_sum,  c_off); // front right
		motor_width[2] = mix_width(p_sum,  c_neg); // rear left
		motor_width[3] = mix_width(p_diff, c_off); // rear right
	end

	// pwm generators; their level flops are the result register payload
	logic [NMOT-1:0] motor_level;

	for (genvar m = 0; m < NMOT; m++) begin : g_pwm
		smpm_pwm u_pwm (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.width  (motor_width[m]),
			.frame  (frame_q),
			.level  (motor_level[m])
		);
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, motor_level};

	`SMPM_ASSERT_NOW(a_stall_blocks_input, clk, arst_n,
		valid_s1 && m_tvalid_q && !m_tready, !s_tready,
		"input taken while the tick in flight is blocked")
	`SMPM_ASSERT_NEXT(a_advance_gives_result, clk, arst_n,
		advance, m_tvalid,
		"tick advanced without a result")
	`SMPM_ASSERT_NEXT(a_levels_hold, clk, arst_n,
		!advance, $stable(motor_level),
		"motor levels moved without a tick")

endmodule

`default_nettype wire

### dv/smpm_motor_check.sv
// tick-level predictor and result checker for the servo pwm mecanum mixer
// depends on smpm_pkg; watches the stream and config ports of servo_pwm_mecanum_mixer
`default_nettype none

module smpm_motor_check #(
	parameter int COUNTER_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire  [7:0] s_tdata,   // [0] x_pin, [1] y_pin, [2] rot_pin
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire  [7:0] m_tdata,   // [0] fl, [1] fr, [2] rl, [3] rr
	input  wire        cfg_wr_en,
	input  wire [11:0] cfg_wr_data,
	output int         errors,
	output int         pending
);
	import smpm_pkg::*;

	typedef enum int {FRONT_LEFT, FRONT_RIGHT, REAR_LEFT, REAR_RIGHT} motor_e;

	// motor pin levels still owed by the block, bit index is motor_e
	logic [3:0] motor_pins_due[$];

	frame_t                  frame_len;
	logic [2:0]              servo_prev;
	logic [COUNTER_BITS-1:0] high_ticks [3];
	cap_t                    pulse_cap  [3];
	width_t                  mot_width  [4];
	countdown_t              mot_cd     [4];
	logic [3:0]              mot_lvl;

	logic [3:0] pins_exp;
	logic [3:0] pins_got;
	motor_e     mot;

	// floor(150 + (d*K - c*2^16) / 2^16), clipped at zero
	function automatic width_t mix_motor(int d, int c);
		longint q;
		q = longint'(NEUTRAL) * (longint'(1) <<< Q_SHIFT)
			+ longint'(d) * HALF_SQRT2_Q16 - longint'(c) * (longint'(1) <<< Q_SHIFT);
		q = q >>> Q_SHIFT;
		if (q < 0)
			q = 0;
		return width_t'(q);
	endfunction

	// one sample tick: pulse capture, mix, then the four pwm countdowns
	function automatic logic [3:0] advance_tick(logic [2:0] pins);
		int a;
		int b;
		int c;
		longint cnt;
		for (int ch = 0; ch < 3; ch++) begin
			if (pins[ch] == servo_prev[ch]) begin
				if (pins[ch] && high_ticks[ch] != '1)
					high_ticks[ch] = high_ticks[ch] + 1'b1;
			end else if (pins[ch]) begin
				high_ticks[ch] = 1;
			end else begin
				cnt = longint'(high_ticks[ch]);
				if (cnt < CAP_MIN)
					cnt = CAP_MIN;
				if (cnt > CAP_MAX)
					cnt = CAP_MAX;
				pulse_cap[ch] = cap_t'(cnt);
			end
			servo_prev[ch] = pins[ch];
		end

		a = int'(pulse_cap[0]) - NEUTRAL;
		b = int'(pulse_cap[1]) - NEUTRAL;
		c = int'(pulse_cap[2]) - NEUTRAL;
		mot_width[FRONT_LEFT]  = mix_motor(a - b, c);
		mot_width[FRONT_RIGHT] = mix_motor(a + b, -c);
		mot_width[REAR_LEFT]   = mix_motor(a + b, c);
		mot_width[REAR_RIGHT]  = mix_motor(a - b, -c);

		for (int m = 0; m < 4; m++) begin
			if (mot_cd[m] <= 1) begin
				if (mot_lvl[m])
					mot_cd[m] = (frame_len > mot_width[m]) ?
						countdown_t'(frame_len - mot_width[m]) : '0;
				else
					mot_cd[m] = countdown_t'(mot_width[m]);
				mot_lvl[m] = !mot_lvl[m];
			end else begin
				mot_cd[m] = mot_cd[m] - 1'b1;
			end
		end
		return mot_lvl;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len  = frame_t'(FRAME_RESET);
			servo_prev = '0;
			mot_lvl    = '0;
			for (int ch = 0; ch < 3; ch++) begin
				high_ticks[ch] = '0;
				pulse_cap[ch]  = cap_t'(NEUTRAL);
			end
			for (int m = 0; m < 4; m++) begin
				mot_width[m] = width_t'(NEUTRAL);
				mot_cd[m]    = '0;
			end
			motor_pins_due.delete();
		end else begin
			if (cfg_wr_en)
				frame_len = cfg_wr_data;
			// retire the oldest owed result before queueing this edge's tick
			if (m_tvalid && m_tready) begin
				pins_got = m_tdata[3:0];
				if (motor_pins_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer, expected none, actual pins %b",
						$time, pins_got);
				end else begin
					pins_exp = motor_pins_due.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (pins_got[i] !== pins_exp[i]) begin
							mot = motor_e'(i);
							errors++;
							$display("%0t: %s pin mismatch, expected %b, actual %b",
								$time, mot.name(), pins_exp[i], pins_got[i]);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				motor_pins_due.push_back(advance_tick(s_tdata[2:0]));
		end
		pending = motor_pins_due.size();
	end

endmodule

`default_nettype wire

### dv/tb_servo_pwm_mecanum_mixer.sv
// testbench top for servo_pwm_mecanum_mixer: clock, reset, tick stimulus, verdict
// depends on smpm_pkg, servo_pwm_mecanum_mixer and the smpm_motor_check checker
`default_nettype none

module tb_servo_pwm_mecanum_mixer;
	import smpm_pkg::*;

	// narrow counter so that its saturation is reached in a short run
	localparam int COUNTER_BITS   = 9;
	localparam int DIRECTED_TICKS = 25;
	localparam int PHASES         = 10;
	localparam int PHASE_TICKS    = 70;    // ~1450 ticks over the whole run
	localparam int STALL_PHASE    = 2;
	localparam int STEADY_PHASE   = 5;
	localparam int STALL_CYCLES   = 60;
	localparam int IDLE_PCT       = 21;
	localparam int SAT_TICKS      = (1 << COUNTER_BITS) + 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       s_tvalid    = 1'b0;
	logic [7:0] s_tdata     = '0;
	logic       m_tready    = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	frame_t     cfg_wr_data = '0;
	wire        s_tready;
	wire        m_tvalid;
	wire  [7:0] m_tdata;

	int errors;
	int pending;
	int quiet_cycles = 0;

	// pressure controls shared with the receiver process
	bit steady     = 1'b0;
	bit stall_req  = 1'b0;
	bit stall_done = 1'b0;

	// servo pulse generators, one per input channel
	logic [2:0] servo_lvl     = '0;
	int         servo_left[3] = '{0, 0, 0};

	frame_t frame_plan[PHASES] = '{12'd400, 12'd0, 12'd4095, 12'd1, 12'd4000,
	                               12'd160, 12'd0, 12'd0, 12'd0, 12'd250};

	// all eight pin combinations, one-tick pulses that clamp to the
	// minimum width (mix saturates at zero) and a few short runs
	logic [2:0] directed_pins[DIRECTED_TICKS] = '{
		3'b000, 3'b111, 3'b000, 3'b001, 3'b000, 3'b010, 3'b011, 3'b001,
		3'b100, 3'b110, 3'b111, 3'b101, 3'b000, 3'b111, 3'b111, 3'b111,
		3'b011, 3'b001, 3'b000, 3'b110, 3'b100, 3'b000, 3'b101, 3'b010,
		3'b000};

	servo_pwm_mecanum_mixer #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),     // [0] x_pin, [1] y_pin, [2] rot_pin, [7:3] zero
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),     // [0] fl, [1] fr, [2] rl, [3] rr, [7:4] zero
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)  // frame_ticks
	);

	smpm_motor_check #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.errors      (errors),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reset once, released away from the rising edge
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// watchdog: ends the run if no transfer happens on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb_servo_pwm_mecanum_mixer: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver: random backpressure, one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (stall_req && !stall_done) begin
				stall_done = 1'b1;
				m_tready <= 1'b0;
				// sender keeps offering meanwhile, so the pipe fills and s_tready drops
				repeat (STALL_CYCLES) @(negedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// next tick from the pulse generators; highs are mostly in the servo
	// range, sometimes far below or above it so the capture clamps, plus
	// occasional single-tick glitches that break a pulse apart
	function automatic logic [2:0] next_servo_pins();
		logic [2:0] glitch;
		for (int ch = 0; ch < 3; ch++) begin
			if (servo_left[ch] == 0) begin
				servo_lvl[ch] = !servo_lvl[ch];
				if (servo_lvl[ch]) begin
					case ($urandom_range(0, 7))
						0: servo_left[ch] = $urandom_range(1, 8);
						1: servo_left[ch] = $urandom_range(240, 420);
						default: servo_left[ch] = $urandom_range(40, 260);
					endcase
				end else begin
					servo_left[ch] = $urandom_range(1, 30);
				end
			end
			servo_left[ch]--;
		end
		glitch = ($urandom_range(0, 99) < 6) ? 3'(1 << $urandom_range(0, 2)) : 3'b000;
		return servo_lvl ^ glitch;
	endfunction

	// one tick transfer; entered and left at a falling edge
	task automatic send_tick(input logic [2:0] pins);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b00000, pins};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop sending and wait until every owed result has come out
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_frame(input frame_t ticks);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ticks;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		frame_plan[6] = frame_t'($urandom_range(2, 700));
		frame_plan[7] = frame_t'($urandom_range(100, 400));
		frame_plan[8] = frame_t'($urandom_range(0, 4095));
		wait (arst_n);
		@(negedge clk);

		// directed ticks under the reset frame length
		foreach (directed_pins[i])
			send_tick(directed_pins[i]);

		// random phases, each with its own frame length; includes a zero
		// frame, a frame below the widths and both top values
		for (int p = 0; p < PHASES; p++) begin
			drain_block();
			write_frame(frame_plan[p]);
			steady = (p == STEADY_PHASE);
			if (p == STALL_PHASE)
				stall_req = 1'b1;
			repeat (PHASE_TICKS)
				send_tick(next_servo_pins());
		end
		steady = 1'b0;

		// long x high pulse: the high-tick counter must stop at all ones,
		// then the falling edge captures the top width
		drain_block();
		write_frame(12'd300);
		send_tick(next_servo_pins() & 3'b110);
		repeat (SAT_TICKS)
			send_tick(next_servo_pins() | 3'b001);
		send_tick(next_servo_pins() & 3'b110);
		repeat (200)
			send_tick(next_servo_pins());

		drain_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_servo_pwm_mecanum_mixer: PASS");
		else
			$display("tb_servo_pwm_mecanum_mixer: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/smpm_pkg.sv
rtl/smpm_channel.sv
rtl/smpm_pwm.sv
rtl/servo_pwm_mecanum_mixer.sv
dv/smpm_motor_check.sv
dv/tb_servo_pwm_mecanum_mixer.sv
